/* sv/clcp_pkg.sv */
// shared constants, types and match words for the console line command parser
`default_nettype none
package clcp_pkg;

  // most characters a line may hold
  localparam int LINE_MAX = 63;
  localparam int LEN_W = $clog2(LINE_MAX + 1);

  // only the head of the line takes part in the match
  localparam int HEAD_DEPTH = 7;
  localparam int HEAD_IDX_W = $clog2(HEAD_DEPTH);
  localparam int CHAR_W = 7;

  localparam logic [7:0] BYTE_BS       = 8'h08;
  localparam logic [7:0] BYTE_LF       = 8'h0A;
  localparam logic [7:0] BYTE_CR       = 8'h0D;
  localparam logic [7:0] BYTE_PRINT_LO = 8'h20;
  localparam logic [7:0] BYTE_PRINT_HI = 8'h7E;
  localparam logic [7:0] BYTE_DEL      = 8'h7F;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [CHAR_W-1:0] head_char_t;

  localparam int HELP_LEN = 4;
  localparam int VERSION_LEN = 7;

  localparam head_char_t WORD_HELP [HELP_LEN] = '{7'h68, 7'h65, 7'h6C, 7'h70};
  localparam head_char_t WORD_VERSION [VERSION_LEN] =
    '{7'h76, 7'h65, 7'h72, 7'h73, 7'h69, 7'h6F, 7'h6E};

  typedef enum logic [1:0] {
    RESP_HELP     = 2'd0,
    RESP_VERSION  = 2'd1,
    RESP_UNKNOWN  = 2'd2,
    RESP_TOO_LONG = 2'd3
  } resp_code_t;

  typedef struct packed {
    logic       emit;
    resp_code_t code;
  } line_result_t;

endpackage
`default_nettype wire

/* sv/console_line_command_parser_core.sv */
// Console line command parser: takes one received byte per transaction and
// returns a response code when a non-empty line ends (0 help, 1 version,
// 2 unknown, 3 line too long). A byte can be accepted every clock cycle; a
// byte is registered on entry and its result, if any, is loaded into the output
// register when that byte advances out of the entry register.
// The rate is set by the update of the line state register, which
// stalls only when a result is due while the output register is still full.
`default_nettype none
module console_line_command_parser_core
  import clcp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      response_code
);

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         advance;
  resp_code_t   out_code;
  line_result_t res;

  clcp_line_state u_line_state (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (s1_byte),
    .result  (res)
  );

  // a byte that yields no result never waits on the output side
  assign advance  = s1_valid && (!res.emit || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign response_code = out_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (advance && res.emit) out_valid <= 1'b1;
      else if (out_ready)      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte <= rx_byte;
    if (advance && res.emit)  out_code <= res.code;
  end

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_byte))
    else $error("held byte lost or changed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    advance && res.emit |-> !out_valid || out_ready)
    else $error("result register overwritten");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance && res.emit |=> out_valid && out_code == $past(res.code))
    else $error("result not loaded");

endmodule
`default_nettype wire

/* sv/clcp_line_state.sv */
// line editing state, head capture and command match for one byte per cycle when stepped
`default_nettype none
module clcp_line_state
  import clcp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         step,
  input  wire logic [7:0]   rx_byte,
  output line_result_t      result
);

  len_t       line_length;
  len_t       line_length_next;
  logic       discard_flag;
  logic       discard_flag_next;
  logic       prev_was_cr;
  logic       prev_was_cr_next;
  head_char_t head_chars [HEAD_DEPTH];

  logic                  head_we;
  logic [HEAD_IDX_W-1:0] head_idx;
  logic                  is_cr;
  logic                  is_lf;
  logic                  end_line;
  logic                  is_erase;
  logic                  is_print;
  logic                  match_help;
  logic                  match_version;

  assign is_cr    = (rx_byte == BYTE_CR);
  assign is_lf    = (rx_byte == BYTE_LF);
  assign end_line = is_cr || (is_lf && !prev_was_cr);
  assign is_erase = (rx_byte == BYTE_BS) || (rx_byte == BYTE_DEL);
  assign is_print = (rx_byte >= BYTE_PRINT_LO) && (rx_byte <= BYTE_PRINT_HI);
  assign head_idx = line_length[HEAD_IDX_W-1:0];

  // head entries below line_length are always written, so only those are compared
  always_comb begin
    match_help = (line_length == LEN_W'(HELP_LEN));
    for (int i = 0; i < HELP_LEN; i++) begin
      if (head_chars[i] != WORD_HELP[i]) match_help = 1'b0;
    end
    match_version = (line_length == LEN_W'(VERSION_LEN));
    for (int i = 0; i < VERSION_LEN; i++) begin
      if (head_chars[i] != WORD_VERSION[i]) match_version = 1'b0;
    end
  end

  always_comb begin
    line_length_next  = line_length;
    discard_flag_next = discard_flag;
    prev_was_cr_next  = is_cr;
    head_we           = 1'b0;
    result.emit       = 1'b0;
    result.code       = RESP_UNKNOWN;
    if (end_line) begin
      if (discard_flag) begin
        result.emit       = 1'b1;
        result.code       = RESP_TOO_LONG;
        line_length_next  = '0;
        discard_flag_next = 1'b0;
      end else if (line_length != '0) begin
        result.emit      = 1'b1;
        line_length_next = '0;
        priority if (match_help) result.code = RESP_HELP;
        else if (match_version)  result.code = RESP_VERSION;
        else                     result.code = RESP_UNKNOWN;
      end
    end else if (!is_lf && !discard_flag) begin
      if (is_erase) begin
        if (line_length != '0) line_length_next = line_length - 1'b1;
      end else if (is_print) begin
        if (line_length != LEN_W'(LINE_MAX)) begin
          line_length_next = line_length + 1'b1;
          head_we          = (line_length < LEN_W'(HEAD_DEPTH));
        end else begin
          discard_flag_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length  <= '0;
      discard_flag <= 1'b0;
      prev_was_cr  <= 1'b0;
    end else if (step) begin
      line_length  <= line_length_next;
      discard_flag <= discard_flag_next;
      prev_was_cr  <= prev_was_cr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && head_we) head_chars[head_idx] <= rx_byte[CHAR_W-1:0];
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= LEN_W'(LINE_MAX))
    else $error("line length beyond limit");

  a_discard_full: assert property (@(posedge clk) disable iff (rst)
    discard_flag |-> line_length == LEN_W'(LINE_MAX))
    else $error("discarding while line not full");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    step && result.emit |=> line_length == '0 && !discard_flag)
    else $error("line not cleared after result");

endmodule
`default_nettype wire
